@@ rtl/wbnd_pkg.sv @@
// Shared constants and pipeline item type for the wide-by-narrow divider.
package wbnd_pkg;

   localparam int FIELD_BITS  = 32;               // width of every payload port
   localparam int WORD_BITS   = 32;               // width of one half / divisor
   localparam int DIV_BITS    = 2 * WORD_BITS;    // dividend and quotient width
   localparam int STEP_BITS   = 2;                // quotient bits resolved per stage
   localparam int STAGE_COUNT = DIV_BITS / STEP_BITS;

   typedef struct packed {
      logic                 zero;  // divisor was zero
      logic [WORD_BITS-1:0] den;   // divisor after the top-bit adjustment
      logic [WORD_BITS-1:0] rem;   // partial remainder, below den whenever den is nonzero
      logic [DIV_BITS-1:0]  nq;    // dividend bits shift out the top, quotient bits in
   } item_type;

endpackage

@@ rtl/wbnd_prep.sv @@
// Input stage: masks the operands, applies the top-bit shift and flags a zero divisor.
module wbnd_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] in_dividend_high,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] in_dividend_low,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] in_divisor,
   output logic                          in_stall,
   output logic                          out_valid,
   output wbnd_pkg::item_type            out_item,
   input  logic                          out_stall
);
   import wbnd_pkg::*;

   logic                 valid_ff;
   item_type             item_ff;
   item_type             item_in;
   logic [DIV_BITS-1:0]  num;
   logic [WORD_BITS-1:0] den;
   logic                 load;

   assign num  = {in_dividend_high[WORD_BITS-1:0], in_dividend_low[WORD_BITS-1:0]};
   assign den  = in_divisor[WORD_BITS-1:0];

   always_comb begin
      item_in.zero = (den == '0);
      item_in.rem  = '0;
      if (den[WORD_BITS-1]) begin
         item_in.nq  = num >> 1;
         item_in.den = den >> 1;
      end else begin
         item_in.nq  = num;
         item_in.den = den;
      end
   end

   // A slot is free when empty or when its beat moves on this cycle.
   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/wbnd_stage.sv @@
// One restoring-division stage: resolves STEP_BITS quotient bits and registers the item.
module wbnd_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  wbnd_pkg::item_type in_item,
   output logic               in_stall,
   output logic               out_valid,
   output wbnd_pkg::item_type out_item,
   input  logic               out_stall
);
   import wbnd_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;
   logic     load;

   always_comb begin
      logic [WORD_BITS:0] trial;
      item_in = in_item;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial      = {item_in.rem, item_in.nq[DIV_BITS-1]};
         item_in.nq = item_in.nq << 1;
         if (trial >= {1'b0, item_in.den}) begin
            trial         = trial - {1'b0, item_in.den};
            item_in.nq[0] = 1'b1;
         end
         item_in.rem = trial[WORD_BITS-1:0];
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign load     = !in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/wide_by_narrow_divider_unit.sv @@
// Top level of the pipelined 64-by-32 unsigned divider.
//
// Request channel: req_valid with req_dividend_high, req_dividend_low and
// req_divisor; a beat is taken at a clock edge where req_valid is high and
// req_stall is low. Response channel: rsp_valid with rsp_quotient_high,
// rsp_quotient_low and rsp_divide_by_zero; the receiver holds rsp_stall
// high to keep the beat in place.
// One request gives one response, in order. A zero divisor sets
// rsp_divide_by_zero and returns a zero quotient. A divisor with its top
// bit set makes both operands shift right by one first, so that quotient
// is approximate.
// One input stage, then stages that each resolve STEP_BITS quotient bits,
// the last stage being the output register. One beat enters per cycle
// while the receiver keeps up.
// A stall at the output holds the last stage; earlier stages keep filling
// their empty slots, and req_stall rises only once every stage is full.
// Synchronous reset empties all stages; no response is pending after it.
module wide_by_narrow_divider_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] req_dividend_high,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] req_dividend_low,
   input  logic [wbnd_pkg::FIELD_BITS-1:0] req_divisor,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output logic [wbnd_pkg::FIELD_BITS-1:0] rsp_quotient_high,
   output logic [wbnd_pkg::FIELD_BITS-1:0] rsp_quotient_low,
   output logic                          rsp_divide_by_zero,
   input  logic                          rsp_stall
);
   import wbnd_pkg::*;

   logic     valid [STAGE_COUNT+1];
   item_type item  [STAGE_COUNT+1];
   logic     stall [STAGE_COUNT+1];
   item_type last;

   wbnd_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_dividend_high (req_dividend_high),
      .in_dividend_low  (req_dividend_low),
      .in_divisor       (req_divisor),
      .in_stall         (req_stall),
      .out_valid        (valid[0]),
      .out_item         (item[0]),
      .out_stall        (stall[0])
   );

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
      wbnd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[s]),
         .in_item   (item[s]),
         .in_stall  (stall[s]),
         .out_valid (valid[s+1]),
         .out_item  (item[s+1]),
         .out_stall (stall[s+1])
      );
   end

   assign stall[STAGE_COUNT] = rsp_stall;
   assign last               = item[STAGE_COUNT];

   // Force the quotient to zero on a zero divisor.
   assign rsp_valid          = valid[STAGE_COUNT];
   assign rsp_divide_by_zero = last.zero;
   assign rsp_quotient_high  = last.zero ? '0 :
                               FIELD_BITS'(last.nq[DIV_BITS-1:WORD_BITS]);
   assign rsp_quotient_low   = last.zero ? '0 :
                               FIELD_BITS'(last.nq[WORD_BITS-1:0]);

endmodule
